// ----- src/udprx_pkg.sv -----
package udprx_pkg;

    // Operation codes on the input channel
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Verdict codes on the result channel
    typedef enum logic [2:0] {
        VERD_OPENED    = 3'd0,
        VERD_FULL      = 3'd1,
        VERD_CLOSED    = 3'd2,
        VERD_LEN_ERR   = 3'd3,
        VERD_CSUM_ERR  = 3'd4,
        VERD_DELIVERED = 3'd5,
        VERD_UNREACH   = 3'd6
    } t_verdict;

    localparam int unsigned SLOT_W    = 6;
    localparam int unsigned HDR_BYTES = 8;
    localparam logic [15:0] PROTO_UDP = 16'd17;

    // Datagram engine outcome for the current beat
    typedef struct packed {
        logic        len_err;
        logic        csum_err;
        logic [15:0] sender_port;
        logic [15:0] target_port;
        logic [15:0] received_sum;
        logic [15:0] computed_sum;
    } t_dg_res;

    // Port table outcome for the current beat
    typedef struct packed {
        logic              oc_full;
        logic [SLOT_W-1:0] oc_slot;
        logic              dl_hit;
        logic [SLOT_W-1:0] dl_slot;
    } t_port_res;

endpackage

// ----- src/udprx_csum.sv -----
module udprx_csum
    import udprx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_local_ip,
    output t_dg_res     o_res
);

    logic [15:0] r_sum, n_sum;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_pend, n_pend;
    logic        r_phase, n_phase;
    logic [15:0] r_hdr [4];
    logic [15:0] n_hdr [4];

    logic        w_in_hdr;
    logic [7:0]  w_byte;
    logic [15:0] w_word;
    logic [16:0] w_pair;
    logic [18:0] w_tree;
    logic [16:0] w_fold1;
    logic [15:0] w_fold2;
    logic [15:0] w_cs;
    logic        w_short;

    assign w_in_hdr = (r_count[15:3] == 13'd0);
    // checksum word counts as zero in the sum
    assign w_byte   = (w_in_hdr && r_count[2:1] == 2'd3) ? 8'd0 : i_data_byte;
    // word this byte contributes: completes a pair, or high byte padded with zero
    assign w_word   = r_phase ? {r_pend, w_byte} : {w_byte, 8'd0};
    assign w_pair   = 17'(r_sum) + 17'({r_pend, w_byte});

    // header capture, byte count and running sum for this beat
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_hdr[k] = r_hdr[k];
        end
        if (w_in_hdr) begin
            if (!r_count[0]) begin
                n_hdr[r_count[2:1]][15:8] = i_data_byte;
            end else begin
                n_hdr[r_count[2:1]][7:0] = i_data_byte;
            end
        end
        n_count = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;
        if (!r_phase) begin
            n_sum   = r_sum;
            n_pend  = w_byte;
            n_phase = 1'b1;
        end else begin
            n_sum   = w_pair[15:0] + 16'(w_pair[16]);
            n_pend  = 8'd0;
            n_phase = 1'b0;
        end
    end

    // final ones'-complement sum: adder tree with end-around fold
    assign w_tree  = 19'(r_sum) + 19'(w_word)
                   + 19'(i_source_address[31:16]) + 19'(i_source_address[15:0])
                   + 19'(i_local_ip[31:16]) + 19'(i_local_ip[15:0])
                   + 19'(PROTO_UDP) + 19'(n_hdr[2]);
    assign w_fold1 = 17'(w_tree[15:0]) + 17'(w_tree[18:16]);
    assign w_fold2 = w_fold1[15:0] + 16'(w_fold1[16]);
    assign w_cs    = ~w_fold2;

    assign w_short = (r_count < 16'(HDR_BYTES - 1)) || (n_hdr[2] < 16'(HDR_BYTES));

    always_comb begin
        o_res.len_err      = w_short;
        o_res.csum_err     = (w_cs != n_hdr[3]);
        o_res.sender_port  = n_hdr[0];
        o_res.target_port  = n_hdr[1];
        o_res.received_sum = n_hdr[3];
        o_res.computed_sum = w_short ? 16'd0 : w_cs;
    end

    // datagram state; a last byte returns it to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_pend  <= '0;
            r_phase <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_hdr[k] <= '0;
            end
        end else if (i_fire) begin
            if (i_last) begin
                r_sum   <= '0;
                r_count <= '0;
                r_pend  <= '0;
                r_phase <= 1'b0;
                for (int k = 0; k < 4; k++) begin
                    r_hdr[k] <= '0;
                end
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
                r_pend  <= n_pend;
                r_phase <= n_phase;
                for (int k = 0; k < 4; k++) begin
                    r_hdr[k] <= n_hdr[k];
                end
            end
        end
    end

endmodule

// ----- src/udprx_ports.sv -----
module udprx_ports
    import udprx_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_open,
    input  logic        i_close,
    input  logic [15:0] i_port_number,
    input  logic [15:0] i_lookup_port,
    output t_port_res   o_res
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [15:0]          r_port [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;

    logic [NUM_SLOTS-1:0] w_match, w_free, w_dl;
    logic [IDX_W-1:0]     w_match_idx, w_free_idx, w_dl_idx;
    logic                 w_any_match, w_any_free;

    // parallel compare against every slot
    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            w_match[k] = (r_port[k] == i_port_number);
            w_free[k]  = !r_valid[k];
            w_dl[k]    = r_valid[k] && (r_port[k] == i_lookup_port);
        end
    end

    // lowest-index priority encoders
    always_comb begin
        w_match_idx = '0;
        w_free_idx  = '0;
        w_dl_idx    = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (w_match[k]) w_match_idx = IDX_W'(k);
            if (w_free[k])  w_free_idx  = IDX_W'(k);
            if (w_dl[k])    w_dl_idx    = IDX_W'(k);
        end
    end

    assign w_any_match = |w_match;
    assign w_any_free  = |w_free;

    always_comb begin
        o_res.oc_full = 1'b0;
        o_res.oc_slot = '0;
        if (i_open) begin
            if (w_any_match) begin
                o_res.oc_slot = SLOT_W'(w_match_idx);
            end else if (w_any_free) begin
                o_res.oc_slot = SLOT_W'(w_free_idx);
            end else begin
                o_res.oc_full = 1'b1;
            end
        end else if (w_any_match) begin
            o_res.oc_slot = SLOT_W'(w_match_idx);
        end
        o_res.dl_hit  = |w_dl;
        o_res.dl_slot = (|w_dl) ? SLOT_W'(w_dl_idx) : '0;
    end

    // table update for open and close beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_port[k] <= '0;
            end
        end else if (i_open) begin
            if (w_any_match) begin
                r_valid[w_match_idx] <= 1'b1;
            end else if (w_any_free) begin
                r_valid[w_free_idx] <= 1'b1;
                r_port[w_free_idx]  <= i_port_number;
            end
        end else if (i_close) begin
            r_valid <= r_valid & ~w_match;
        end
    end

endmodule

// ----- src/udp_receive_check_and_port_demux_core.sv -----
// Pipeline: two register stages; a beat accepted into the input register passes its result
//   to the output register, which drives the outputs.
// Throughput: one beat per cycle; the input register stalls only while the output
//   register holds a result that the sink is stalling.
// Reset (i_rst_n, synchronous): datagram state, port table, local IP and both
//   handshake stages clear at once; no clearing pass.
module udp_receive_check_and_port_demux_core
    import udprx_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic [31:0] i_source_address,
    input  logic [15:0] i_port_number,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_local_ip,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_verdict,
    output logic [5:0]  o_slot,
    output logic [15:0] o_sender_port,
    output logic [15:0] o_target_port,
    output logic [15:0] o_received_sum,
    output logic [15:0] o_computed_sum
);

    logic [31:0] r_local_ip;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_in_op;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [31:0] r_in_src;
    logic [15:0] r_in_port;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_out_verdict;
    logic [5:0]  r_out_slot;
    logic [15:0] r_out_sp, r_out_dp, r_out_rx, r_out_cs;

    t_op         w_op;
    logic        w_has_res, w_out_free, w_adv, w_accept;
    t_dg_res     w_dg;
    t_port_res   w_pt;
    t_verdict    n_verdict;
    logic [5:0]  n_slot;
    logic [15:0] n_sp, n_dp, n_rx, n_cs;

    assign w_op = t_op'(r_in_op);

    always_comb begin
        unique case (w_op)
            OP_BYTE:  w_has_res = r_in_last;
            OP_OPEN:  w_has_res = 1'b1;
            OP_CLOSE: w_has_res = 1'b1;
            OP_NONE:  w_has_res = 1'b0;
            default:  w_has_res = 1'b0;
        endcase
    end

    // handshake: beats without a result never wait on the sink
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_adv      = r_in_valid && (w_out_free || !w_has_res);
    assign o_stall    = r_in_valid && !w_adv;
    assign w_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    udprx_csum u_csum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_adv && (w_op == OP_BYTE)),
        .i_data_byte      (r_in_byte),
        .i_last           (r_in_last),
        .i_source_address (r_in_src),
        .i_local_ip       (r_local_ip),
        .o_res            (w_dg)
    );

    udprx_ports #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ports (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_open        (w_adv && (w_op == OP_OPEN)),
        .i_close       (w_adv && (w_op == OP_CLOSE)),
        .i_port_number (r_in_port),
        .i_lookup_port (w_dg.target_port),
        .o_res         (w_pt)
    );

    // result assembly
    always_comb begin
        n_verdict = VERD_OPENED;
        n_slot    = '0;
        n_sp      = '0;
        n_dp      = '0;
        n_rx      = '0;
        n_cs      = '0;
        unique case (w_op)
            OP_OPEN: begin
                n_verdict = w_pt.oc_full ? VERD_FULL : VERD_OPENED;
                n_slot    = w_pt.oc_slot;
            end
            OP_CLOSE: begin
                n_verdict = VERD_CLOSED;
                n_slot    = w_pt.oc_slot;
            end
            OP_BYTE: begin
                n_sp = w_dg.sender_port;
                n_dp = w_dg.target_port;
                n_rx = w_dg.received_sum;
                n_cs = w_dg.computed_sum;
                priority if (w_dg.len_err) begin
                    n_verdict = VERD_LEN_ERR;
                end else if (w_dg.csum_err) begin
                    n_verdict = VERD_CSUM_ERR;
                end else if (w_pt.dl_hit) begin
                    n_verdict = VERD_DELIVERED;
                    n_slot    = w_pt.dl_slot;
                end else begin
                    n_verdict = VERD_UNREACH;
                end
            end
            default: begin
                n_verdict = VERD_OPENED;
            end
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_local_ip <= i_cfg_local_ip;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op   <= i_operation;
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
            r_in_src  <= i_source_address;
            r_in_port <= i_port_number;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_has_res) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_has_res) begin
            r_out_verdict <= n_verdict;
            r_out_slot    <= n_slot;
            r_out_sp      <= n_sp;
            r_out_dp      <= n_dp;
            r_out_rx      <= n_rx;
            r_out_cs      <= n_cs;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_verdict      = r_out_verdict;
    assign o_slot         = r_out_slot;
    assign o_sender_port  = r_out_sp;
    assign o_target_port  = r_out_dp;
    assign o_received_sum = r_out_rx;
    assign o_computed_sum = r_out_cs;

endmodule
